@@ src/gnlsc_pkg.sv @@
// ----------------------------------------------------------------------------
// gnlsc_pkg
// Shared types and constants for the grind controller with no-load stop.
// ----------------------------------------------------------------------------
`default_nettype none

package gnlsc_pkg;

    // Register reset values
    localparam logic [7:0]  GRIND_PWM_RST      = 8'd200;
    localparam logic [11:0] IDLE_THRESHOLD_RST = 12'd50;
    localparam logic [7:0]  STABLE_NEEDED_RST  = 8'd5;
    localparam logic [15:0] CHECK_INTERVAL_RST = 16'd100;

    // Samples averaged per check (1..15)
    localparam int unsigned SAMPLES_PER_CHECK_DEF = 10;

    // Fixed-point shift for the divide-by-constant reciprocal; exact for
    // 16-bit sums and divisors below 16
    localparam int unsigned DIV_SHIFT = 20;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_GRIND = 2'd1,
        MODE_DONE  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_START  = 2'd1,
        FUNC_STOP   = 2'd2,
        FUNC_SAMPLE = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_STARTED     = 3'd1,
        EV_ALREADY     = 3'd2,
        EV_STOPPED     = 3'd3,
        EV_NOT_GRIND   = 3'd4,
        EV_TIMEOUT     = 3'd5,
        EV_NOLOAD_DONE = 3'd6,
        EV_CHECK_OPEN  = 3'd7
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRIND_PWM      = 2'd0,
        CFG_IDLE_THRESHOLD = 2'd1,
        CFG_STABLE_NEEDED  = 2'd2,
        CFG_CHECK_INTERVAL = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] duration_ms;
        logic [11:0] current_sample;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  motor_duty;
        logic [2:0]  event_res;
        logic [7:0]  idle_count;
        logic [11:0] average_current;
    } t_out_item;

endpackage

`default_nettype wire

@@ src/grind_no_load_stop_controller.sv @@
// An accepted result enters the result register, or the skid if the output
// stalls. Throughput: one transaction per cycle while input is ready; the whole
// state update is one combinational pass between the state registers and the
// result register. A two-entry output (result register plus skid) keeps input
// ready while one result waits. Reset (synchronous, active low) sets idle mode,
// clears all timers and counts, empties the output and loads register defaults.
// ----------------------------------------------------------------------------
// grind_no_load_stop_controller
// Grinding motor controller that stops on stop command, timeout or no load.
// ----------------------------------------------------------------------------
`default_nettype none

module grind_no_load_stop_controller #(
    parameter int unsigned SAMPLES_PER_CHECK = gnlsc_pkg::SAMPLES_PER_CHECK_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // input channel
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  gnlsc_pkg::t_in_item                  i_in_data,
    // output channel
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output gnlsc_pkg::t_out_item                 o_out_data,
    // configuration writes
    input  wire                                  i_cfg_we,
    input  wire [gnlsc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [gnlsc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int unsigned RECIP_W = gnlsc_pkg::DIV_SHIFT + 1;
    localparam int unsigned RECIP   =
        ((1 << gnlsc_pkg::DIV_SHIFT) + SAMPLES_PER_CHECK - 1) / SAMPLES_PER_CHECK;
    localparam int unsigned PROD_W  = 16 + RECIP_W;

    // Configuration registers
    logic [7:0]  r_grind_pwm;
    logic [11:0] r_idle_threshold;
    logic [7:0]  r_stable_needed;
    logic [15:0] r_check_interval;

    // Controller state
    gnlsc_pkg::t_mode r_mode, n_mode;
    logic [31:0] r_elapsed, n_elapsed;
    logic [31:0] r_limit, n_limit;
    logic [15:0] r_since_check, n_since_check;
    logic [15:0] r_sum, n_sum;
    logic [3:0]  r_taken, n_taken;
    logic        r_check_open, n_check_open;
    logic [7:0]  r_low_count, n_low_count;
    logic [11:0] r_last_avg, n_last_avg;
    gnlsc_pkg::t_event n_event;

    // Output staging
    logic                 r_out_valid, n_out_valid;
    logic                 r_skid_valid, n_skid_valid;
    gnlsc_pkg::t_out_item r_out_data, n_out_data;
    gnlsc_pkg::t_out_item r_skid_data, n_skid_data;
    gnlsc_pkg::t_out_item res;

    logic accept;
    logic pop;

    // Sample path helpers
    logic [15:0]       sum_add;
    logic [3:0]        taken_add;
    logic [PROD_W-1:0] avg_prod;
    logic [11:0]       avg;
    logic [7:0]        low_inc;

    assign o_in_ready  = !r_skid_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign pop         = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Average by reciprocal multiply: floor(sum / N), which fits the 12-bit result for any sum of N 12-bit samples
    assign sum_add   = r_sum + 16'(i_in_data.current_sample);
    assign taken_add = r_taken + 4'd1;
    assign avg_prod  = PROD_W'(sum_add) * PROD_W'(RECIP);
    assign avg       = avg_prod[gnlsc_pkg::DIV_SHIFT +: 12];
    assign low_inc   = (r_low_count == 8'hFF) ? r_low_count : r_low_count + 8'd1;

    // Next controller state
    always_comb begin
        n_mode        = r_mode;
        n_elapsed     = r_elapsed;
        n_limit       = r_limit;
        n_since_check = r_since_check;
        n_sum         = r_sum;
        n_taken       = r_taken;
        n_check_open  = r_check_open;
        n_low_count   = r_low_count;
        n_last_avg    = r_last_avg;
        n_event       = gnlsc_pkg::EV_NONE;
        if (accept) begin
            unique case (gnlsc_pkg::t_func'(i_in_data.func))
                gnlsc_pkg::FUNC_TICK: begin
                    if (r_since_check != 16'hFFFF) begin
                        n_since_check = r_since_check + 16'd1;
                    end
                    if (r_mode == gnlsc_pkg::MODE_GRIND) begin
                        if (r_elapsed != 32'hFFFF_FFFF) begin
                            n_elapsed = r_elapsed + 32'd1;
                        end
                        if (n_elapsed >= r_limit) begin
                            n_mode       = gnlsc_pkg::MODE_DONE;
                            n_check_open = 1'b0;
                            n_sum        = '0;
                            n_taken      = '0;
                            n_event      = gnlsc_pkg::EV_TIMEOUT;
                        end else if (!r_check_open && n_since_check >= r_check_interval) begin
                            n_since_check = '0;
                            n_check_open  = 1'b1;
                            n_sum         = '0;
                            n_taken       = '0;
                            n_event       = gnlsc_pkg::EV_CHECK_OPEN;
                        end
                    end
                end
                gnlsc_pkg::FUNC_START: begin
                    if (r_mode == gnlsc_pkg::MODE_GRIND) begin
                        n_event = gnlsc_pkg::EV_ALREADY;
                    end else begin
                        n_mode       = gnlsc_pkg::MODE_GRIND;
                        n_limit      = i_in_data.duration_ms;
                        n_elapsed    = '0;
                        n_low_count  = '0;
                        n_last_avg   = '0;
                        n_check_open = 1'b0;
                        n_sum        = '0;
                        n_taken      = '0;
                        n_event      = gnlsc_pkg::EV_STARTED;
                    end
                end
                gnlsc_pkg::FUNC_STOP: begin
                    if (r_mode == gnlsc_pkg::MODE_GRIND) begin
                        n_mode       = gnlsc_pkg::MODE_DONE;
                        n_check_open = 1'b0;
                        n_sum        = '0;
                        n_taken      = '0;
                        n_event      = gnlsc_pkg::EV_STOPPED;
                    end else begin
                        n_event = gnlsc_pkg::EV_NOT_GRIND;
                    end
                end
                gnlsc_pkg::FUNC_SAMPLE: begin
                    if (r_check_open && r_mode == gnlsc_pkg::MODE_GRIND) begin
                        n_sum   = sum_add;
                        n_taken = taken_add;
                        // check complete: update the no-load run
                        if (taken_add >= 4'(SAMPLES_PER_CHECK)) begin
                            n_last_avg   = avg;
                            n_check_open = 1'b0;
                            n_sum        = '0;
                            n_taken      = '0;
                            if (avg <= r_idle_threshold) begin
                                n_low_count = low_inc;
                                if (low_inc >= r_stable_needed) begin
                                    n_mode  = gnlsc_pkg::MODE_DONE;
                                    n_event = gnlsc_pkg::EV_NOLOAD_DONE;
                                end
                            end else begin
                                n_low_count = '0;
                            end
                        end
                    end
                end
                default: begin
                    n_event = gnlsc_pkg::EV_NONE;
                end
            endcase
        end
    end

    // Result fields from the updated state
    always_comb begin
        res.mode            = n_mode;
        res.motor_duty      = (n_mode == gnlsc_pkg::MODE_GRIND) ? r_grind_pwm : 8'd0;
        res.event_res       = n_event;
        res.idle_count      = n_low_count;
        res.average_current = n_last_avg;
    end

    // Output register and skid stage
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = accept;
                n_out_data  = res;
            end
        end else if (accept) begin
            n_skid_valid = 1'b1;
            n_skid_data  = res;
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= gnlsc_pkg::MODE_IDLE;
            r_elapsed     <= '0;
            r_limit       <= '0;
            r_since_check <= '0;
            r_sum         <= '0;
            r_taken       <= '0;
            r_check_open  <= 1'b0;
            r_low_count   <= '0;
            r_last_avg    <= '0;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            r_mode        <= n_mode;
            r_elapsed     <= n_elapsed;
            r_limit       <= n_limit;
            r_since_check <= n_since_check;
            r_sum         <= n_sum;
            r_taken       <= n_taken;
            r_check_open  <= n_check_open;
            r_low_count   <= n_low_count;
            r_last_avg    <= n_last_avg;
            r_out_valid   <= n_out_valid;
            r_skid_valid  <= n_skid_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grind_pwm      <= gnlsc_pkg::GRIND_PWM_RST;
            r_idle_threshold <= gnlsc_pkg::IDLE_THRESHOLD_RST;
            r_stable_needed  <= gnlsc_pkg::STABLE_NEEDED_RST;
            r_check_interval <= gnlsc_pkg::CHECK_INTERVAL_RST;
        end else if (i_cfg_we) begin
            unique case (gnlsc_pkg::t_cfg_reg'(i_cfg_index))
                gnlsc_pkg::CFG_GRIND_PWM:      r_grind_pwm      <= i_cfg_data[7:0];
                gnlsc_pkg::CFG_IDLE_THRESHOLD: r_idle_threshold <= i_cfg_data[11:0];
                gnlsc_pkg::CFG_STABLE_NEEDED:  r_stable_needed  <= i_cfg_data[7:0];
                gnlsc_pkg::CFG_CHECK_INTERVAL: r_check_interval <= i_cfg_data[15:0];
                default: begin
                    r_grind_pwm <= r_grind_pwm;
                end
            endcase
        end
    end

    // Checks on internal consistency
    a_check_only_grinding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_check_open |-> r_mode == gnlsc_pkg::MODE_GRIND)
        else $error("check open outside grinding");

    a_taken_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_taken < 4'(SAMPLES_PER_CHECK))
        else $error("sample count reached check size without closing");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output register is empty");

    a_duty_off_when_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.mode != gnlsc_pkg::MODE_GRIND)
            |-> r_out_data.motor_duty == 8'd0)
        else $error("motor duty nonzero outside grinding");

    a_idle_count_cleared_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_event == gnlsc_pkg::EV_STARTED)
            |=> (r_low_count == 8'd0 && r_mode == gnlsc_pkg::MODE_GRIND))
        else $error("start did not arm grinding with a cleared idle count");

endmodule

`default_nettype wire
